FILE: rtl/core/rod_pkg.sv
`default_nettype none
package rod_pkg;

	localparam int unsigned MAG_W   = 32;
	localparam int unsigned STIFF_W = 48;
	localparam int unsigned REST_W  = 31;
	localparam int unsigned OUT_W   = 48;
	localparam int unsigned PROD_W  = 128;
	localparam int unsigned OPND_W  = 64;

	// iteration counts of the shared units
	localparam int unsigned MUL_STEPS  = 4;
	localparam int unsigned DIV_STEPS  = 128;
	localparam int unsigned SQRT_STEPS = 32;

	// one classified edge: magnitudes and signs split apart
	typedef struct packed {
		logic                          mode;
		logic [2:0]                    neg;
		logic [2:0][MAG_W-1:0]         mag;
		logic [STIFF_W-1:0]            k;
		logic [REST_W-1:0]             r;
	} item_t;

	// front to back request
	typedef struct packed {
		logic  valid;
		item_t item;
	} item_req_t;

	typedef enum logic [4:0] {
		E_IDLE,
		E_SQ,
		E_SQRT,
		E_LEN,
		E_RL,
		E_F_P,
		E_F_N,
		E_F_D,
		E_EN_P,
		E_EN_N,
		E_EN_D,
		E_T1_N,
		E_T1_D,
		E_LL,
		E_M_P,
		E_M_Q,
		E_M_N,
		E_M_D,
		E_OUT
	} eng_state_t;

	// clamp a magnitude with sign into signed 48 bits
	function automatic logic [OUT_W-1:0] sat_s48(input logic [PROD_W-1:0] m, input logic neg);
		logic [OUT_W-1:0] lim;
		logic [OUT_W-1:0] v;
		lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		v = ((|m[PROD_W-1:OUT_W]) || (m[OUT_W-1:0] > lim)) ? lim : m[OUT_W-1:0];
		return neg ? (48'd0 - v) : v;
	endfunction

	// clamp to unsigned 48 bits
	function automatic logic [OUT_W-1:0] sat_u48(input logic [PROD_W-1:0] m);
		return (|m[PROD_W-1:OUT_W]) ? 48'hFFFF_FFFF_FFFF : m[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rod_front.sv
`default_nettype none
module rod_front #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [175:0]        in_data,
	output rod_pkg::item_req_t       req,
	input  wire logic                pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rod_pkg::item_t   mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	rod_pkg::item_t   cls;
	logic             push;
	logic             take;
	logic [31:0]      comp [3];

	// classify: split each component into sign and magnitude
	always_comb begin
		cls.mode = in_data[0];
		comp[0]  = in_data[32:1];
		comp[1]  = in_data[64:33];
		comp[2]  = in_data[96:65];
		for (int i = 0; i < 3; i++) begin
			cls.neg[i] = comp[i][31];
			cls.mag[i] = comp[i][31] ? (32'd0 - comp[i]) : comp[i];
		end
		cls.k = in_data[144:97];
		cls.r = in_data[175:145];
	end

	assign in_ready = (count_q < CW'(DEPTH));
	assign push     = in_valid && in_ready;
	assign take     = pop && (count_q != '0);

	assign req.valid = (count_q != '0);
	assign req.item  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue overfilled");

endmodule
`default_nettype wire

FILE: rtl/core/rod_mul.sv
`default_nettype none
module rod_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   a,
	input  wire logic [63:0]   b,
	output logic               done,
	output logic [127:0]       p
);

	logic [63:0]  a_q, b_q;
	logic [127:0] p_q;
	logic [1:0]   cnt_q;
	logic         run_q, done_q;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [1:0]   sh;
	logic [127:0] pp_ext;

	// one 32x32 partial product per cycle
	always_comb begin
		ah     = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		bh     = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp     = ah * bh;
		sh     = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		pp_ext = {64'd0, pp} << {sh, 5'd0};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (run_q) begin
			p_q <= p_q + pp_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'(rod_pkg::MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule
`default_nettype wire

FILE: rtl/core/rod_div.sv
`default_nettype none
module rod_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [127:0]  n,
	input  wire logic [63:0]   d,
	output logic               done,
	output logic [127:0]       q
);

	logic [127:0] nq_q;
	logic [63:0]  d_q, rem_q;
	logic [6:0]   cnt_q;
	logic         run_q, done_q;
	logic [64:0]  rem_sh, rem_nx;
	logic         ge;

	// restoring step: one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, nq_q[127]};
		ge     = (rem_sh >= {1'b0, d_q});
		rem_nx = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (run_q) begin
			nq_q  <= {nq_q[126:0], ge};
			rem_q <= rem_nx[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 7'(rod_pkg::DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = nq_q;

endmodule
`default_nettype wire

FILE: rtl/core/rod_engine.sv
`default_nettype none
module rod_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rod_pkg::item_req_t  req,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [191:0]             out_data,
	output logic [2:0]               out_user,
	output logic                     out_last
);

	rod_pkg::eng_state_t state_q, state_nx;
	rod_pkg::item_t      item_q;
	logic                pend_q;
	logic [1:0]          i_q, j_q;
	logic [63:0]         x_q, res_q, bit_q;
	logic [4:0]          scnt_q;
	logic [31:0]         len_q, dlr_q;
	logic                degen_q, shorter_q;
	logic [63:0]         d_rl_q, d_ll_q;
	logic [127:0]        t1_q;
	logic [47:0]         val_q [3];
	logic [47:0]         en_q;

	logic                mvalid_q, mlast_q, mdegen_q;
	logic [1:0]          mrow_q;
	logic [47:0]         ma_q, mb_q, mc_q, men_q;

	logic                mul_start, div_start, mul_done, div_done;
	logic [63:0]         mul_a, mul_b, div_d;
	logic [127:0]        mul_p, div_n, div_q;
	logic                is_mul, is_div, op_done, out_free, out_load, last_row;
	logic [63:0]         sq_try, res_nx;
	logic                n2, sneg;
	logic [127:0]        msum;

	rod_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	rod_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .q(div_q)
	);

	// which unit each state drives
	always_comb begin
		case (state_q)
			rod_pkg::E_SQ, rod_pkg::E_RL, rod_pkg::E_F_P, rod_pkg::E_F_N,
			rod_pkg::E_EN_P, rod_pkg::E_EN_N, rod_pkg::E_T1_N, rod_pkg::E_LL,
			rod_pkg::E_M_P, rod_pkg::E_M_N: begin
				is_mul = 1'b1;
				is_div = 1'b0;
			end
			rod_pkg::E_F_D, rod_pkg::E_EN_D, rod_pkg::E_T1_D,
			rod_pkg::E_M_Q, rod_pkg::E_M_D: begin
				is_mul = 1'b0;
				is_div = 1'b1;
			end
			default: begin
				is_mul = 1'b0;
				is_div = 1'b0;
			end
		endcase
	end

	assign op_done  = (is_mul && mul_done) || (is_div && div_done);
	assign out_free = !mvalid_q || out_ready;
	assign last_row = !item_q.mode || (i_q == 2'd2);

	// square root step
	always_comb begin
		sq_try = res_q + bit_q;
		res_nx = (x_q >= sq_try) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	end

	// stiffness block entry: diagonal adds the length term
	always_comb begin
		n2 = item_q.neg[i_q] ^ item_q.neg[j_q];
		if (i_q != j_q) begin
			msum = div_q;
			sneg = n2;
		end else if (shorter_q == n2) begin
			msum = t1_q + div_q;
			sneg = n2;
		end else if (t1_q >= div_q) begin
			msum = t1_q - div_q;
			sneg = shorter_q;
		end else begin
			msum = div_q - t1_q;
			sneg = n2;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rod_pkg::E_IDLE: if (req.valid) state_nx = rod_pkg::E_SQ;
			rod_pkg::E_SQ:   if (op_done && i_q == 2'd2) state_nx = rod_pkg::E_SQRT;
			rod_pkg::E_SQRT: begin
				if (scnt_q == 5'(rod_pkg::SQRT_STEPS - 1)) state_nx = rod_pkg::E_LEN;
			end
			rod_pkg::E_LEN: begin
				state_nx = (len_q == '0 || item_q.r == '0) ? rod_pkg::E_OUT : rod_pkg::E_RL;
			end
			rod_pkg::E_RL: begin
				if (op_done) state_nx = item_q.mode ? rod_pkg::E_T1_N : rod_pkg::E_F_P;
			end
			rod_pkg::E_F_P:  if (op_done) state_nx = rod_pkg::E_F_N;
			rod_pkg::E_F_N:  if (op_done) state_nx = rod_pkg::E_F_D;
			rod_pkg::E_F_D: begin
				if (op_done) state_nx = (i_q == 2'd2) ? rod_pkg::E_EN_P : rod_pkg::E_F_P;
			end
			rod_pkg::E_EN_P: if (op_done) state_nx = rod_pkg::E_EN_N;
			rod_pkg::E_EN_N: if (op_done) state_nx = rod_pkg::E_EN_D;
			rod_pkg::E_EN_D: if (op_done) state_nx = rod_pkg::E_OUT;
			rod_pkg::E_T1_N: if (op_done) state_nx = rod_pkg::E_T1_D;
			rod_pkg::E_T1_D: if (op_done) state_nx = rod_pkg::E_LL;
			rod_pkg::E_LL:   if (op_done) state_nx = rod_pkg::E_M_P;
			rod_pkg::E_M_P:  if (op_done) state_nx = rod_pkg::E_M_Q;
			rod_pkg::E_M_Q:  if (op_done) state_nx = rod_pkg::E_M_N;
			rod_pkg::E_M_N:  if (op_done) state_nx = rod_pkg::E_M_D;
			rod_pkg::E_M_D: begin
				if (op_done) state_nx = (j_q == 2'd2) ? rod_pkg::E_OUT : rod_pkg::E_M_P;
			end
			rod_pkg::E_OUT: begin
				if (out_free) begin
					if (last_row) state_nx = rod_pkg::E_IDLE;
					else if (degen_q) state_nx = rod_pkg::E_OUT;
					else state_nx = rod_pkg::E_M_P;
				end
			end
			default: state_nx = rod_pkg::E_IDLE;
		endcase
	end

	// unit requests and operand selection
	always_comb begin
		mul_start = is_mul && !pend_q;
		div_start = is_div && !pend_q;
		pop       = (state_q == rod_pkg::E_IDLE) && req.valid;
		out_load  = (state_q == rod_pkg::E_OUT) && out_free;
		mul_a     = '0;
		mul_b     = '0;
		div_n     = mul_p;
		div_d     = d_rl_q;
		case (state_q)
			rod_pkg::E_SQ: begin
				mul_a = {32'd0, item_q.mag[i_q]};
				mul_b = {32'd0, item_q.mag[i_q]};
			end
			rod_pkg::E_RL: begin
				mul_a = {33'd0, item_q.r};
				mul_b = {32'd0, len_q};
			end
			rod_pkg::E_F_P: begin
				mul_a = {32'd0, dlr_q};
				mul_b = {32'd0, item_q.mag[i_q]};
			end
			rod_pkg::E_F_N, rod_pkg::E_EN_N: begin
				mul_a = {16'd0, item_q.k};
				mul_b = mul_p[63:0];
			end
			rod_pkg::E_EN_P: begin
				mul_a = {32'd0, dlr_q};
				mul_b = {32'd0, dlr_q};
			end
			rod_pkg::E_T1_N: begin
				mul_a = {16'd0, item_q.k};
				mul_b = {16'd0, dlr_q, 16'd0};
			end
			rod_pkg::E_LL: begin
				mul_a = {32'd0, len_q};
				mul_b = {32'd0, len_q};
			end
			rod_pkg::E_M_P: begin
				mul_a = {32'd0, item_q.mag[i_q]};
				mul_b = {32'd0, item_q.mag[j_q]};
			end
			rod_pkg::E_M_N: begin
				mul_a = {16'd0, item_q.k};
				mul_b = div_q[63:0];
			end
			rod_pkg::E_EN_D: div_d = {16'd0, item_q.r, 17'd0};
			rod_pkg::E_M_Q: begin
				div_n = {32'd0, mul_p[63:0], 32'd0};
				div_d = d_ll_q;
			end
			rod_pkg::E_M_D: div_d = {16'd0, len_q, 16'd0};
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rod_pkg::E_IDLE;
			pend_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (mul_start || div_start) pend_q <= 1'b1;
			else if (op_done) pend_q <= 1'b0;
			if (out_load) mvalid_q <= 1'b1;
			else if (out_ready) mvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rod_pkg::E_IDLE: begin
				if (req.valid) begin
					item_q <= req.item;
					x_q    <= '0;
					res_q  <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
					scnt_q <= '0;
					i_q    <= '0;
				end
			end
			rod_pkg::E_SQ: begin
				if (op_done) begin
					x_q <= x_q + mul_p[63:0];
					i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
				end
			end
			rod_pkg::E_SQRT: begin
				if (x_q >= sq_try) x_q <= x_q - sq_try;
				res_q  <= res_nx;
				bit_q  <= bit_q >> 2;
				scnt_q <= scnt_q + 1'b1;
				len_q  <= res_nx[31:0];
			end
			rod_pkg::E_LEN: begin
				degen_q   <= (len_q == '0) || (item_q.r == '0);
				shorter_q <= len_q < {1'b0, item_q.r};
				dlr_q     <= (len_q < {1'b0, item_q.r}) ? ({1'b0, item_q.r} - len_q)
				                                        : (len_q - {1'b0, item_q.r});
				for (int k = 0; k < 3; k++) val_q[k] <= '0;
				en_q <= '0;
				i_q  <= '0;
				j_q  <= '0;
			end
			rod_pkg::E_RL: if (op_done) d_rl_q <= mul_p[63:0];
			rod_pkg::E_F_D: begin
				if (op_done) begin
					val_q[i_q] <= rod_pkg::sat_s48(div_q, shorter_q ^ item_q.neg[i_q]);
					i_q        <= (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
				end
			end
			rod_pkg::E_EN_D: if (op_done) en_q <= rod_pkg::sat_u48(div_q);
			rod_pkg::E_T1_D: if (op_done) t1_q <= div_q;
			rod_pkg::E_LL:   if (op_done) d_ll_q <= mul_p[63:0];
			rod_pkg::E_M_D: begin
				if (op_done) begin
					val_q[j_q] <= rod_pkg::sat_s48(msum, sneg);
					if (j_q != 2'd2) j_q <= j_q + 1'b1;
				end
			end
			rod_pkg::E_OUT: begin
				if (out_free && !last_row) begin
					i_q <= i_q + 1'b1;
					j_q <= '0;
				end
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			ma_q     <= val_q[0];
			mb_q     <= val_q[1];
			mc_q     <= val_q[2];
			men_q    <= en_q;
			mrow_q   <= item_q.mode ? i_q : 2'd0;
			mdegen_q <= degen_q;
			mlast_q  <= last_row;
		end
	end

	assign out_valid = mvalid_q;
	assign out_data  = {men_q, mc_q, mb_q, ma_q};
	assign out_user  = {mdegen_q, mrow_q};
	assign out_last  = mlast_q;

	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rod_pkg::E_SQRT |-> $onehot(bit_q)) else $error("sqrt bit lost");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q && mdegen_q |-> (ma_q == '0 && mb_q == '0 && mc_q == '0 && men_q == '0))
		else $error("degenerate result not zero");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q && !mlast_q |-> (mrow_q == 2'd0 || mrow_q == 2'd1))
		else $error("row after last");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !(mul_start || div_start)) else $error("unit started twice");

endmodule
`default_nettype wire

FILE: rtl/core/rod_edge_stretch_force.sv
// Stretching force of one elastic rod edge, signed Q16.16 in, Q32.16 out.
// Slave channel s_axis_*: one request per edge (mode, edge vector,
// stiffness, rest length). Master channel m_axis_*: mode 0 gives one
// request with force and energy, mode 1 gives three requests, the rows of
// the 3x3 stiffness block, tlast on the final one.
// Work runs on one shared 64x64 multiplier (4 partial products an
// operation, with start and done), one radix-2 128/64 divider and a
// bit-pair square root. A mode 0 edge needs four divisions and a mode 1
// edge nineteen, unless it is degenerate; the divider sets the rate.
// The input queue takes further edges while the engine works, and the
// output register holds a result while the sink stalls; the engine waits
// only on the output register. Reset empties queue and output; no
// clearing pass is needed.
`default_nettype none
module rod_edge_stretch_force #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// mode, edge_x, edge_y, edge_z, stiffness, rest_length
	input  wire logic [175:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// out_a, out_b, out_c, energy
	output logic [191:0]       m_axis_tdata,
	// row_index, degenerate
	output logic [2:0]         m_axis_tuser,
	output logic               m_axis_tlast
);

	rod_pkg::item_req_t req;
	logic               pop;

	// front: accept, classify, queue
	rod_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.req(req), .pop(pop)
	);

	// back: arithmetic sequencer and output register
	rod_engine u_engine (
		.clk(clk), .arst_n(arst_n), .req(req), .pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast)
	);

endmodule
`default_nettype wire
